[hw/rtl/channel_activity_history_macros.svh]
// channel_activity_history_macros.svh: assertion macros for the activity history block
// no dependencies; included by modules that carry concurrent checks
`ifndef CHANNEL_ACTIVITY_HISTORY_MACROS_SVH
`define CHANNEL_ACTIVITY_HISTORY_MACROS_SVH

// same-cycle implication, disabled during reset
`define CAH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CAH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/cah_pkg.sv]
// cah_pkg.sv: types, constants and defaults for the channel activity history block
// no dependencies; used by channel_activity_history, cah_sec_div and cah_hist_core
`default_nettype none

package cah_pkg;

	// field widths fixed by the word formats; a 64-bit ms count needs 55 bits of seconds
	localparam int unsigned MS_W   = 64;
	localparam int unsigned CNT_W  = 32;
	localparam int unsigned SEC_W  = 55;
	localparam int unsigned FLAG_W = 4;
	localparam int unsigned ROW_W  = 20;

	// default parameter values
	localparam int unsigned HISTORY_LEN_DEF  = 60;
	localparam int unsigned CELL_SPAN_DEF    = 3;
	localparam int unsigned COUNTER_BITS_DEF = 32;

	// flag coding of one history entry
	localparam logic [FLAG_W-1:0] FLAG_NONE    = 4'h0;
	localparam logic [FLAG_W-1:0] FLAG_UNKNOWN = 4'h8;
	localparam int unsigned FLAG_RX_BIT   = 0;
	localparam int unsigned FLAG_TX_BIT   = 1;
	localparam int unsigned FLAG_BUSY_BIT = 2;
	localparam int unsigned FLAG_UNK_BIT  = 3;

	// ms to seconds: 1000 = 125 << 3, so shift by 3, then divide by 125 one
	// 16-bit digit per stage; each digit step is a reciprocal multiplication
	// floor(v * RECIP >> 30), exact for any v below 125 * 2^16
	localparam int unsigned MS_SHIFT       = 3;
	localparam int unsigned REM_W          = 7;
	localparam logic [REM_W:0] DIV_CONST   = 8'd125;
	localparam int unsigned WORK_W         = 64;
	localparam int unsigned DIV_DIGIT_W    = 16;
	localparam int unsigned DIV_STAGES     = WORK_W / DIV_DIGIT_W;
	localparam int unsigned DIV_V_W        = REM_W + DIV_DIGIT_W;
	localparam int unsigned RECIP_W        = 24;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 24'd8589935;
	localparam int unsigned RECIP_SHIFT    = 30;

	typedef struct packed {
		logic [MS_W-1:0]  now_ms;
		logic             telemetry_valid;
		logic [CNT_W-1:0] rx_frames;
		logic [CNT_W-1:0] tx_frames;
		logic [CNT_W-1:0] busy_count;
	} in_word_t;

	typedef struct packed {
		logic             telemetry_valid;
		logic [CNT_W-1:0] rx_frames;
		logic [CNT_W-1:0] tx_frames;
		logic [CNT_W-1:0] busy_count;
	} side_t;

	typedef struct packed {
		logic [SEC_W-1:0] second;
		side_t            side;
	} sec_word_t;

	typedef struct packed {
		logic              history_moved;
		logic [FLAG_W-1:0] newest_flags;
		logic [ROW_W-1:0]  rx_row;
		logic [ROW_W-1:0]  tx_row;
		logic [ROW_W-1:0]  busy_row;
		logic [ROW_W-1:0]  unknown_row;
	} out_word_t;

endpackage

`default_nettype wire

[hw/rtl/cah_chan_if.sv]
// cah_chan_if.sv: valid/ready channel carrying one word of a given payload type
// no dependencies; payload types come from cah_pkg at the instantiation
`default_nettype none

interface cah_chan_if #(
	parameter type payload_t = logic [0:0]
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/channel_activity_history.sv]
// channel_activity_history.sv: top level of the one-minute radio activity history
// depends on cah_pkg, cah_chan_if, cah_sec_div and cah_hist_core
//
//   channel  dir  payload      contents
//   item     in   in_word_t    now_ms, telemetry_valid, rx/tx/busy counters
//   result   out  out_word_t   history_moved, newest_flags, four 20-bit cell rows
//
// one word accepted per cycle unless the divide stages are full and blocked; the accepted word
// passes through four divide-by-1000 stages (16 quotient bits each) into the history core,
// which loads the result register from it
// reset is immediate: history reads all unknown at once, no clearing pass
// a stage holds only when the stage after it is full and blocked, so bubbles collapse;
// while a result waits the input keeps taking words until the divide stages are full
`default_nettype none

module channel_activity_history #(
	parameter int unsigned HISTORY_LEN  = cah_pkg::HISTORY_LEN_DEF,
	parameter int unsigned CELL_SPAN    = cah_pkg::CELL_SPAN_DEF,
	parameter int unsigned COUNTER_BITS = cah_pkg::COUNTER_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cah_chan_if.sink    item,
	cah_chan_if.source  result
);

	// seconds channel between divider and history core
	cah_chan_if #(.payload_t(cah_pkg::sec_word_t)) sec_ch ();

	cah_sec_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.sec    (sec_ch.source)
	);

	cah_hist_core #(
		.HISTORY_LEN  (HISTORY_LEN),
		.CELL_SPAN    (CELL_SPAN),
		.COUNTER_BITS (COUNTER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.sec    (sec_ch.sink),
		.result (result)
	);

endmodule

`default_nettype wire

[hw/rtl/cah_sec_div.sv]
// cah_sec_div.sv: pipelined millisecond to second conversion, counters ride alongside
// depends on cah_pkg and cah_chan_if
`default_nettype none

module cah_sec_div (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cah_chan_if.sink    item,
	cah_chan_if.source  sec
);

	typedef struct packed {
		logic [cah_pkg::REM_W-1:0]  rem;
		logic [cah_pkg::WORK_W-1:0] work;
	} div_state_t;

	localparam int unsigned PROD_W = cah_pkg::DIV_V_W + cah_pkg::RECIP_W;

	// one stage: next 16-bit digit divided by 125 through the reciprocal,
	// remainder carried on, quotient digit shifted in at the bottom
	function automatic div_state_t div_step(input div_state_t st);
		div_state_t                       r;
		logic [cah_pkg::DIV_V_W-1:0]      v;
		logic [PROD_W-1:0]                prod;
		logic [cah_pkg::DIV_DIGIT_W-1:0]  q;
		logic [cah_pkg::DIV_V_W-1:0]      diff;
		v = {st.rem, st.work[cah_pkg::WORK_W-1 -: cah_pkg::DIV_DIGIT_W]};
		prod = PROD_W'(v) * PROD_W'(cah_pkg::DIV_RECIP);
		q = prod[cah_pkg::RECIP_SHIFT +: cah_pkg::DIV_DIGIT_W];
		diff = v - cah_pkg::DIV_V_W'(q) * cah_pkg::DIV_V_W'(cah_pkg::DIV_CONST);
		r.rem = diff[cah_pkg::REM_W-1:0];
		r.work = {st.work[cah_pkg::WORK_W-cah_pkg::DIV_DIGIT_W-1:0], q};
		return r;
	endfunction

	localparam int unsigned N = cah_pkg::DIV_STAGES;

	logic [N-1:0]                div_valid_s;
	div_state_t [N-1:0]          div_state_s;
	cah_pkg::side_t [N-1:0]      div_side_s;

	logic [N:0]                  load_ok;
	logic [N-1:0]                stg_valid_in;
	div_state_t [N-1:0]          stg_state_in;
	cah_pkg::side_t [N-1:0]      stg_side_in;

	// per-stage load enable, bubbles collapse
	always_comb begin
		load_ok[N] = sec.ready;
		for (int k = N - 1; k >= 0; k--) begin
			load_ok[k] = !div_valid_s[k] || load_ok[k+1];
		end
	end

	// stage inputs
	always_comb begin
		stg_valid_in[0] = item.valid;
		stg_state_in[0].rem = '0;
		stg_state_in[0].work = cah_pkg::WORK_W'(item.data.now_ms >> cah_pkg::MS_SHIFT);
		stg_side_in[0].telemetry_valid = item.data.telemetry_valid;
		stg_side_in[0].rx_frames = item.data.rx_frames;
		stg_side_in[0].tx_frames = item.data.tx_frames;
		stg_side_in[0].busy_count = item.data.busy_count;
		for (int k = 1; k < N; k++) begin
			stg_valid_in[k] = div_valid_s[k-1];
			stg_state_in[k] = div_state_s[k-1];
			stg_side_in[k] = div_side_s[k-1];
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_valid_s <= '0;
		end else begin
			for (int k = 0; k < N; k++) begin
				if (load_ok[k]) begin
					div_valid_s[k] <= stg_valid_in[k];
				end
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			if (load_ok[k] && stg_valid_in[k]) begin
				div_state_s[k] <= div_step(stg_state_in[k]);
				div_side_s[k] <= stg_side_in[k];
			end
		end
	end

	assign item.ready = load_ok[0];
	assign sec.valid = div_valid_s[N-1];
	assign sec.data.second = div_state_s[N-1].work[cah_pkg::SEC_W-1:0];
	assign sec.data.side = div_side_s[N-1];

endmodule

`default_nettype wire

[hw/rtl/cah_hist_core.sv]
// cah_hist_core.sv: history state, shift and flag update, cell summary and result register
// depends on cah_pkg, cah_chan_if and channel_activity_history_macros.svh
`default_nettype none

`include "channel_activity_history_macros.svh"

module cah_hist_core #(
	parameter int unsigned HISTORY_LEN  = cah_pkg::HISTORY_LEN_DEF,
	parameter int unsigned CELL_SPAN    = cah_pkg::CELL_SPAN_DEF,
	parameter int unsigned COUNTER_BITS = cah_pkg::COUNTER_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cah_chan_if.sink    sec,
	cah_chan_if.source  result
);

	localparam int unsigned FW      = cah_pkg::FLAG_W;
	localparam int unsigned SHIFT_W = $clog2(HISTORY_LEN + 1);
	localparam int unsigned CW      = (COUNTER_BITS < cah_pkg::CNT_W) ? COUNTER_BITS
		: cah_pkg::CNT_W;
	localparam int unsigned CELLS_RAW = HISTORY_LEN / CELL_SPAN;
	localparam int unsigned NCELLS    = (CELLS_RAW < cah_pkg::ROW_W) ? CELLS_RAW
		: cah_pkg::ROW_W;

	typedef logic [HISTORY_LEN-1:0][FW-1:0] hist_t;

	// state
	hist_t                     hist_q;
	logic                      started_q;
	logic [cah_pkg::SEC_W-1:0] last_sec_q;
	logic [CW-1:0]             last_rx_q;
	logic [CW-1:0]             last_tx_q;
	logic [CW-1:0]             last_busy_q;
	logic                      last_valid_q;

	// result register
	logic                      res_v_q;
	cah_pkg::out_word_t        res_q;

	logic                      acc;
	logic                      same;
	logic                      restart;
	logic                      fresh;
	logic [cah_pkg::SEC_W-1:0] elapsed;
	logic [SHIFT_W-1:0]        shift_n;
	logic [CW-1:0]             rx_c;
	logic [CW-1:0]             tx_c;
	logic [CW-1:0]             busy_c;
	logic [2*HISTORY_LEN*FW-1:0] ext;
	hist_t                     hist_shift;
	hist_t                     hist_d;
	logic [FW-1:0]             newest;
	logic [cah_pkg::ROW_W-1:0] rows_d [FW];
	logic [FW-1:0]             cell_acc;

	assign acc = sec.valid && sec.ready;
	assign sec.ready = !res_v_q || result.ready;

	assign rx_c = sec.data.side.rx_frames[CW-1:0];
	assign tx_c = sec.data.side.tx_frames[CW-1:0];
	assign busy_c = sec.data.side.busy_count[CW-1:0];

	// second compare and elapsed time
	assign same = started_q && (sec.data.second == last_sec_q);
	assign restart = !started_q || (sec.data.second < last_sec_q);
	assign elapsed = sec.data.second - last_sec_q;
	assign shift_n = (elapsed > cah_pkg::SEC_W'(HISTORY_LEN)) ? SHIFT_W'(HISTORY_LEN)
		: elapsed[SHIFT_W-1:0];

	// shift toward the oldest end, unknown fills in at the newest end
	assign ext = {{HISTORY_LEN{cah_pkg::FLAG_UNKNOWN}}, hist_q};
	always_comb begin
		logic [2*HISTORY_LEN*FW-1:0] sh;
		sh = ext >> {shift_n, 2'b00};
		hist_shift = sh[HISTORY_LEN*FW-1:0];
	end

	// newest entry gets change bits after exactly one clean second
	assign fresh = (elapsed == cah_pkg::SEC_W'(1)) && last_valid_q
		&& sec.data.side.telemetry_valid
		&& (rx_c >= last_rx_q) && (tx_c >= last_tx_q) && (busy_c >= last_busy_q);

	always_comb begin
		newest = cah_pkg::FLAG_NONE;
		newest[cah_pkg::FLAG_RX_BIT] = (rx_c != last_rx_q);
		newest[cah_pkg::FLAG_TX_BIT] = (tx_c != last_tx_q);
		newest[cah_pkg::FLAG_BUSY_BIT] = (busy_c != last_busy_q);
	end

	// next history
	always_comb begin
		priority if (same) begin
			hist_d = hist_q;
		end else if (restart) begin
			hist_d = {HISTORY_LEN{cah_pkg::FLAG_UNKNOWN}};
		end else begin
			hist_d = hist_shift;
			if (fresh) begin
				hist_d[HISTORY_LEN-1] = newest;
			end
		end
	end

	// cell summary over the next history
	always_comb begin
		for (int b = 0; b < int'(FW); b++) begin
			rows_d[b] = '0;
		end
		cell_acc = '0;
		for (int c = 0; c < int'(NCELLS); c++) begin
			cell_acc = '0;
			for (int k = 0; k < int'(CELL_SPAN); k++) begin
				cell_acc = cell_acc | hist_d[c*CELL_SPAN + k];
			end
			for (int b = 0; b < int'(FW); b++) begin
				rows_d[b][c] = cell_acc[b];
			end
		end
	end

	// history and last-sample state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= {HISTORY_LEN{cah_pkg::FLAG_UNKNOWN}};
			started_q <= 1'b0;
			last_sec_q <= '0;
			last_rx_q <= '0;
			last_tx_q <= '0;
			last_busy_q <= '0;
			last_valid_q <= 1'b0;
		end else if (acc) begin
			hist_q <= hist_d;
			if (!same) begin
				started_q <= 1'b1;
				last_sec_q <= sec.data.second;
				last_rx_q <= rx_c;
				last_tx_q <= tx_c;
				last_busy_q <= busy_c;
				last_valid_q <= sec.data.side.telemetry_valid;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (acc) begin
			res_v_q <= 1'b1;
		end else if (result.ready) begin
			res_v_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			res_q.history_moved <= !same;
			res_q.newest_flags <= hist_d[HISTORY_LEN-1];
			res_q.rx_row <= rows_d[cah_pkg::FLAG_RX_BIT];
			res_q.tx_row <= rows_d[cah_pkg::FLAG_TX_BIT];
			res_q.busy_row <= rows_d[cah_pkg::FLAG_BUSY_BIT];
			res_q.unknown_row <= rows_d[cah_pkg::FLAG_UNK_BIT];
		end
	end

	assign result.valid = res_v_q;
	assign result.data = res_q;

	// checks
	`CAH_ASSERT_NEXT(a_repeat_keeps_history, clk, arst_n, acc && same, $stable(hist_q), "repeated second changed the history")
	`CAH_ASSERT_NEXT(a_started_after_word, clk, arst_n, acc, started_q, "not started after an accepted word")
	`CAH_ASSERT_NEXT(a_restart_newest_unknown, clk, arst_n, acc && restart, res_q.newest_flags == cah_pkg::FLAG_UNKNOWN, "restart left newest entry known")
	`CAH_ASSERT_NOW(a_newest_coding, clk, arst_n, res_v_q, !(res_q.newest_flags[cah_pkg::FLAG_UNK_BIT] && (|res_q.newest_flags[cah_pkg::FLAG_BUSY_BIT:cah_pkg::FLAG_RX_BIT])), "unknown newest entry carries activity bits")

endmodule

`default_nettype wire

[verif/channel_activity_history_tb.sv]
`timescale 1ns / 1ps
// channel_activity_history_tb.sv: self-checking bench for the one-minute activity history
// depends on cah_pkg, cah_chan_if and channel_activity_history; a class predicts each summary

module channel_activity_history_tb;

	localparam int unsigned HIST   = cah_pkg::HISTORY_LEN_DEF;
	localparam int unsigned SPAN   = cah_pkg::CELL_SPAN_DEF;
	localparam int unsigned CELLS  = (HIST / SPAN > cah_pkg::ROW_W) ? cah_pkg::ROW_W
		: HIST / SPAN;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 60;
	localparam int unsigned SETTLE_CYCLES = 20;

	// keeps its own copy of the history and queues the summaries it predicts
	class history_predictor;
		logic [cah_pkg::FLAG_W-1:0] flags [HIST];
		bit                         started;
		logic [cah_pkg::MS_W-1:0]   last_sec;
		logic [cah_pkg::CNT_W-1:0]  last_rx;
		logic [cah_pkg::CNT_W-1:0]  last_tx;
		logic [cah_pkg::CNT_W-1:0]  last_busy;
		bit                         last_valid;
		cah_pkg::out_word_t         due_summaries[$];
		int unsigned                errors;

		function new();
			foreach (flags[i]) flags[i] = cah_pkg::FLAG_UNKNOWN;
			started    = 1'b0;
			last_sec   = '0;
			last_rx    = '0;
			last_tx    = '0;
			last_busy  = '0;
			last_valid = 1'b0;
			errors     = 0;
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			if (errors <= 50)
				$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		endtask

		// update the history for one accepted word and queue the summary it yields
		function void note_sample(cah_pkg::in_word_t w);
			logic [cah_pkg::MS_W-1:0]   sec;
			logic [cah_pkg::MS_W-1:0]   gap;
			int unsigned                shift;
			logic [cah_pkg::FLAG_W-1:0] acc;
			logic [cah_pkg::FLAG_W-1:0] fresh;
			cah_pkg::out_word_t         e;

			sec = w.now_ms / 64'd1000;
			e = '0;
			if (!(started && sec == last_sec)) begin
				e.history_moved = 1'b1;
				if (!started || sec < last_sec) begin
					foreach (flags[i]) flags[i] = cah_pkg::FLAG_UNKNOWN;
					started = 1'b1;
				end else begin
					gap = sec - last_sec;
					shift = (gap > HIST) ? HIST : 32'(gap);
					for (int i = 0; i < HIST; i++)
						flags[i] = (i + shift < HIST) ? flags[i + shift] : cah_pkg::FLAG_UNKNOWN;
					if (gap == 1 && last_valid && w.telemetry_valid &&
							w.rx_frames >= last_rx && w.tx_frames >= last_tx &&
							w.busy_count >= last_busy) begin
						fresh = cah_pkg::FLAG_NONE;
						fresh[cah_pkg::FLAG_RX_BIT]   = (w.rx_frames != last_rx);
						fresh[cah_pkg::FLAG_TX_BIT]   = (w.tx_frames != last_tx);
						fresh[cah_pkg::FLAG_BUSY_BIT] = (w.busy_count != last_busy);
						flags[HIST-1] = fresh;
					end
				end
				last_sec   = sec;
				last_rx    = w.rx_frames;
				last_tx    = w.tx_frames;
				last_busy  = w.busy_count;
				last_valid = w.telemetry_valid;
			end

			// fold three-second cells into the four rows
			for (int c = 0; c < CELLS; c++) begin
				acc = cah_pkg::FLAG_NONE;
				for (int k = 0; k < SPAN; k++)
					acc |= flags[c * SPAN + k];
				e.rx_row[c]      = acc[cah_pkg::FLAG_RX_BIT];
				e.tx_row[c]      = acc[cah_pkg::FLAG_TX_BIT];
				e.busy_row[c]    = acc[cah_pkg::FLAG_BUSY_BIT];
				e.unknown_row[c] = acc[cah_pkg::FLAG_UNK_BIT];
			end
			e.newest_flags = flags[HIST-1];
			due_summaries.push_back(e);
		endfunction

		// compare one summary word with the oldest prediction
		task check_summary(cah_pkg::out_word_t got);
			cah_pkg::out_word_t want;

			if (due_summaries.size() == 0) begin
				report("unexpected summary", 64'(got), 64'd0);
			end else begin
				want = due_summaries.pop_front();
				if (got.history_moved !== want.history_moved)
					report("history_moved", 64'(got.history_moved), 64'(want.history_moved));
				if (got.newest_flags !== want.newest_flags)
					report("newest_flags", 64'(got.newest_flags), 64'(want.newest_flags));
				if (got.rx_row !== want.rx_row)
					report("rx_row", 64'(got.rx_row), 64'(want.rx_row));
				if (got.tx_row !== want.tx_row)
					report("tx_row", 64'(got.tx_row), 64'(want.tx_row));
				if (got.busy_row !== want.busy_row)
					report("busy_row", 64'(got.busy_row), 64'(want.busy_row));
				if (got.unknown_row !== want.unknown_row)
					report("unknown_row", 64'(got.unknown_row), 64'(want.unknown_row));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	cah_chan_if #(.payload_t(cah_pkg::in_word_t))  item_ch ();
	cah_chan_if #(.payload_t(cah_pkg::out_word_t)) result_ch ();

	channel_activity_history dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	history_predictor tracker;

	int unsigned send_idle;
	int unsigned recv_stall;
	bit          hold_req;

	// stimulus generator state: time and running counters
	logic [cah_pkg::MS_W-1:0]  gen_ms;
	logic [cah_pkg::CNT_W-1:0] gen_rx;
	logic [cah_pkg::CNT_W-1:0] gen_tx;
	logic [cah_pkg::CNT_W-1:0] gen_busy;

	always #6 clk = ~clk;

	// note accepted words and check summaries
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				tracker.note_sample(item_ch.data);
			if (result_ch.valid && result_ch.ready)
				tracker.check_summary(result_ch.data);
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	// watchdog on cycles with no handshake on either side
	initial begin : watchdog
		int unsigned quiet;

		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// offer one word after a random gap and hold it until taken
	task automatic send_word(cah_pkg::in_word_t w);
		while ($urandom_range(0, 99) < send_idle) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= w;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic send_counts(logic [cah_pkg::MS_W-1:0] ms, bit v,
			logic [cah_pkg::CNT_W-1:0] rx, logic [cah_pkg::CNT_W-1:0] tx,
			logic [cah_pkg::CNT_W-1:0] busy);
		cah_pkg::in_word_t w;

		w.now_ms          = ms;
		w.telemetry_valid = v;
		w.rx_frames       = rx;
		w.tx_frames       = tx;
		w.busy_count      = busy;
		send_word(w);
	endtask

	// stop offering and wait for every predicted summary; the first edge lets the
	// monitor note the last accepted word
	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.due_summaries.size() != 0) @(posedge clk);
	endtask

	task automatic bump_counters();
		if ($urandom_range(0, 2) != 0) gen_rx   += $urandom_range(1, 1000);
		if ($urandom_range(0, 2) != 0) gen_tx   += $urandom_range(1, 1000);
		if ($urandom_range(0, 2) != 0) gen_busy += $urandom_range(1, 1000);
	endtask

	// mostly consecutive seconds with growing counters, the rest gaps and breaks
	task automatic make_word(output cah_pkg::in_word_t w);
		logic [cah_pkg::MS_W-1:0] sec;
		int unsigned              kind;

		sec  = gen_ms / 64'd1000;
		kind = $urandom_range(0, 99);
		w.telemetry_valid = ($urandom_range(0, 9) != 0);
		if (kind < 55) begin
			sec += 64'd1;
			bump_counters();
		end else if (kind < 70) begin
			bump_counters();
		end else if (kind < 80) begin
			sec += 64'($urandom_range(2, 70));
			bump_counters();
		end else if (kind < 86) begin
			sec += 64'd1;
			case ($urandom_range(0, 2))
				0: gen_rx   -= $urandom_range(1, 100);
				1: gen_tx   -= $urandom_range(1, 100);
				default: gen_busy -= $urandom_range(1, 100);
			endcase
		end else if (kind < 91) begin
			sec -= 64'($urandom_range(1, 100));
		end else begin
			sec      = {$urandom, $urandom} / 64'd1000;
			gen_rx   = $urandom;
			gen_tx   = $urandom;
			gen_busy = $urandom;
		end
		gen_ms = sec * 64'd1000 + 64'($urandom_range(0, 999));
		if (kind >= 97)
			gen_ms = {$urandom, $urandom};
		w.now_ms     = gen_ms;
		w.rx_frames  = gen_rx;
		w.tx_frames  = gen_tx;
		w.busy_count = gen_busy;
	endtask

	task automatic run_phase(int unsigned count, int unsigned s_idle, int unsigned r_idle);
		cah_pkg::in_word_t w;

		send_idle  = s_idle;
		recv_stall = r_idle;
		repeat (count) begin
			make_word(w);
			send_word(w);
		end
		drain();
	endtask

	initial begin
		tracker = new();
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		result_ch.ready = 1'b0;
		send_idle       = 0;
		recv_stall      = 0;
		hold_req        = 1'b0;
		gen_ms          = 64'd5000;
		gen_rx          = '0;
		gen_tx          = '0;
		gen_busy        = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first word, each flag, repeated second, invalid samples,
		// counter going back, gaps, time going back, extreme values
		send_counts(64'd0,      1'b1, 0, 0, 0);
		send_counts(64'd999,    1'b1, 7, 7, 7);
		send_counts(64'd1000,   1'b1, 1, 0, 0);
		send_counts(64'd2000,   1'b1, 1, 1, 0);
		send_counts(64'd3000,   1'b1, 1, 1, 1);
		send_counts(64'd4999,   1'b1, 2, 2, 2);
		send_counts(64'd5000,   1'b1, 2, 2, 2);
		send_counts(64'd5500,   1'b0, 0, 0, 0);
		send_counts(64'd6000,   1'b0, 3, 3, 3);
		send_counts(64'd7000,   1'b1, 4, 4, 4);
		send_counts(64'd8000,   1'b1, 9, 4, 4);
		send_counts(64'd9000,   1'b1, 8, 5, 5);
		send_counts(64'd10000,  1'b1, 8, 6, 5);
		send_counts(64'd12000,  1'b1, 9, 6, 5);
		send_counts(64'd13000,  1'b1, 9, 7, 5);
		send_counts(64'd73000,  1'b1, 9, 7, 6);
		send_counts(64'd74000,  1'b1, 10, 7, 6);
		send_counts(64'd200000, 1'b1, 11, 7, 6);
		send_counts(64'd201000, 1'b1, '1, '1, '1);
		send_counts(64'd202000, 1'b1, '1, '1, '1);
		send_counts(64'd203000, 1'b1, 0, 0, 0);
		send_counts(64'd1000,   1'b1, 0, 0, 0);
		send_counts('1,         1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
		send_counts(64'd18446744073709551000, 1'b1, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hF0F0_F0F0);
		drain();

		// long receiver hold-off while words keep coming, so the input backs up
		hold_req = 1'b1;
		run_phase(40, 0, 0);

		run_phase(103, 0, 0);
		run_phase(103, 71, 0);
		run_phase(103, 0, 71);
		run_phase(103, 28, 28);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.due_summaries.size() != 0)
			tracker.report("summaries never seen", 64'(tracker.due_summaries.size()), 64'd0);
		if (tracker.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
